FILE: src/pfd_pkg.sv
// Shared types, constants and helpers for the filtered-derivative PID block.
// No dependencies; every other file in src imports this package.
package pfd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int IO_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int LIMIT_WIDTH = 31;

    // Multiplier: one 16-bit digit of the A operand per cycle against a
    // 33-bit signed B operand (holds signed gains and unsigned 31-bit values).
    localparam int DIGIT = 16;
    localparam int B_WIDTH = 33;

    // Filter coefficients in Q0.16.
    localparam int COEF_NEW = 25166;
    localparam int COEF_OLD = 40305;

    // Each gain term is clamped to +-2^TERM_SHIFT before the final sum.
    localparam int TERM_SHIFT = 61;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 31'd131072;
    localparam logic [LIMIT_WIDTH-1:0] STEP_RESET = 31'd65;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_STEP = 3'd4;

    typedef struct packed {
        logic [IO_WIDTH-1:0]    gain_p;
        logic [IO_WIDTH-1:0]    gain_i;
        logic [IO_WIDTH-1:0]    gain_d;
        logic [LIMIT_WIDTH-1:0] integral_limit;
        logic [LIMIT_WIDTH-1:0] integral_step;
    } cfg_t;

    // Width of the rounded product (a*b + 2^15) >> 16 for an A operand of
    // a_width bits, after padding A to whole digits.
    function automatic int q_width(input int a_width);
        int nd;
        nd = (a_width + DIGIT - 1) / DIGIT;
        return nd * DIGIT + B_WIDTH - DIGIT;
    endfunction

endpackage

FILE: src/pfd_in_if.sv
// Input channel of the PID block: handshake plus one sample item.
// Depends on pfd_pkg for the field width.
interface pfd_in_if;
    import pfd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [IO_WIDTH-1:0] target;
    logic signed [IO_WIDTH-1:0] measured;
    logic                       clear_integrator;

    modport source (output valid, output target, output measured,
                    output clear_integrator, input ready);
    modport sink (input valid, input target, input measured,
                  input clear_integrator, output ready);
endinterface

FILE: src/pfd_out_if.sv
// Output channel of the PID block: handshake plus the controller drive item.
// Depends on pfd_pkg for the field width.
interface pfd_out_if;
    import pfd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [IO_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

FILE: src/pfd_mul.sv
// Digit-serial signed multiplier with Q16 rounding: q = (a*b + 2^15) >>> 16.
// Depends on pfd_pkg. After start the sequence is a load step, one step per digit
// and a rounding step, after which done rises.
module pfd_mul #(
    parameter int A_WIDTH = pfd_pkg::DATA_WIDTH_DEF + 1
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic signed [A_WIDTH-1:0]                         a,
    input  logic signed [pfd_pkg::B_WIDTH-1:0]                b,
    output logic                                              done,
    output logic signed [pfd_pkg::q_width(A_WIDTH)-1:0]       q
);
    import pfd_pkg::*;

    localparam int ND = (A_WIDTH + DIGIT - 1) / DIGIT;
    localparam int AP = ND * DIGIT;
    localparam int PW = AP + B_WIDTH;
    localparam int QW = PW - DIGIT;
    localparam int CW = (ND > 1) ? $clog2(ND) : 1;
    localparam int ROUND_HALF = 1 << (DIGIT - 1);

    logic [AP-1:0]                 a_reg, a_next;
    logic signed [B_WIDTH-1:0]     b_reg, b_next;
    logic signed [PW-1:0]          acc_reg, acc_next;
    logic signed [QW-1:0]          q_reg, q_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          rnd_reg, rnd_next;
    logic                          done_reg, done_next;

    logic [DIGIT-1:0]              top_digit;
    logic signed [DIGIT:0]         digit_s;
    logic signed [DIGIT+B_WIDTH:0] prod;
    logic signed [PW-1:0]          rounded;

    // Horner order: the most significant digit (the only signed one) comes first.
    assign top_digit = a_reg[AP-1 -: DIGIT];
    assign digit_s = (cnt_reg == CW'(ND - 1)) ? {top_digit[DIGIT-1], top_digit}
                                              : {1'b0, top_digit};
    assign prod = digit_s * b_reg;
    assign rounded = acc_reg + PW'(ROUND_HALF);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        rnd_next = 1'b0;
        done_next = rnd_reg;
        if (rnd_reg)
        begin
            q_next = rounded[PW-1:DIGIT];
        end
        if (busy_reg)
        begin
            acc_next = (acc_reg <<< DIGIT) + PW'(prod);
            a_next = a_reg << DIGIT;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                rnd_next = 1'b1;
            end
        end
        else if (start)
        begin
            a_next = AP'(a);
            b_next = b;
            acc_next = '0;
            cnt_next = CW'(ND - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            rnd_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            rnd_reg <= rnd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule

FILE: src/pfd_core.sv
// Sequencer and state of the PID channel: drives the shared multiplier through
// six products per item and applies saturation, filtering and clamping.
// Depends on pfd_pkg; works with pfd_mul.
module pfd_core #(
    parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  pfd_pkg::cfg_t                                     cfg,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic signed [pfd_pkg::IO_WIDTH-1:0]               target,
    input  logic signed [pfd_pkg::IO_WIDTH-1:0]               measured,
    input  logic                                              clear_integrator,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic signed [pfd_pkg::IO_WIDTH-1:0]               drive,
    output logic                                              mul_start,
    output logic signed [DATA_WIDTH:0]                        mul_a,
    output logic signed [pfd_pkg::B_WIDTH-1:0]                mul_b,
    input  logic                                              mul_done,
    input  logic signed [pfd_pkg::q_width(DATA_WIDTH+1)-1:0]  mul_q
);
    import pfd_pkg::*;

    localparam int AW = DATA_WIDTH + 1;
    localparam int QW = q_width(AW);
    localparam int SW = QW + 2;
    localparam int TW = (QW > 64) ? QW : 64;

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DATA_WIDTH+1){1'b0}},
                                                {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [TW-1:0] TERM_MAX = TW'(64'sd1 <<< TERM_SHIFT);
    localparam logic signed [TW-1:0] TERM_MIN = -TERM_MAX;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (IO_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = ~OUT_MAX;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        OP_DIFF,
        OP_FILT,
        OP_INTEG,
        OP_PROP,
        OP_DERIV,
        OP_INTGAIN
    } op_t;

    state_t                        state_reg, state_next;
    op_t                           op_reg, op_next;
    logic signed [DATA_WIDTH-1:0]  prev_err_reg, prev_err_next;
    logic signed [DATA_WIDTH-1:0]  filt_reg, filt_next;
    logic signed [DATA_WIDTH-1:0]  integ_reg, integ_next;
    logic signed [DATA_WIDTH-1:0]  err_reg, err_next;
    logic                          clr_reg, clr_next;
    logic signed [QW-1:0]          part_reg, part_next;
    logic signed [63:0]            acc_reg, acc_next;
    logic signed [IO_WIDTH-1:0]    drive_reg, drive_next;

    logic signed [IO_WIDTH:0]      diff_in;
    logic signed [SW-1:0]          lim;
    logic signed [SW-1:0]          integ_sum;
    logic signed [SW-1:0]          integ_clamped;
    logic signed [63:0]            out_sum;

    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        y = x;
        if (x > SAT_MAX)
        begin
            y = SAT_MAX;
        end
        else if (x < SAT_MIN)
        begin
            y = SAT_MIN;
        end
        return y[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [63:0] term(input logic signed [QW-1:0] x);
        logic signed [TW-1:0] y;
        y = TW'(x);
        if (y > TERM_MAX)
        begin
            y = TERM_MAX;
        end
        else if (y < TERM_MIN)
        begin
            y = TERM_MIN;
        end
        return y[63:0];
    endfunction

    assign diff_in = (IO_WIDTH+1)'(target) - (IO_WIDTH+1)'(measured);
    assign lim = SW'(signed'({1'b0, cfg.integral_limit}));

    // Integrator update: optional clear, add err*step, clamp to the limit.
    assign integ_sum = (clr_reg ? SW'(0) : SW'(integ_reg)) + SW'(mul_q);
    always_comb
    begin
        integ_clamped = integ_sum;
        if (integ_sum > lim)
        begin
            integ_clamped = lim;
        end
        else if (integ_sum < -lim)
        begin
            integ_clamped = -lim;
        end
    end

    assign out_sum = acc_reg + term(mul_q);

    // Operand selection for the product each step issues.
    always_comb
    begin
        case (op_reg)
            OP_DIFF:
            begin
                mul_a = AW'(err_reg) - AW'(prev_err_reg);
                mul_b = B_WIDTH'(COEF_NEW);
            end
            OP_FILT:
            begin
                mul_a = AW'(filt_reg);
                mul_b = B_WIDTH'(COEF_OLD);
            end
            OP_INTEG:
            begin
                mul_a = AW'(err_reg);
                mul_b = B_WIDTH'({1'b0, cfg.integral_step});
            end
            OP_PROP:
            begin
                mul_a = AW'(err_reg);
                mul_b = B_WIDTH'(signed'(cfg.gain_p));
            end
            OP_DERIV:
            begin
                mul_a = AW'(filt_reg);
                mul_b = B_WIDTH'(signed'(cfg.gain_d));
            end
            OP_INTGAIN:
            begin
                mul_a = AW'(integ_reg);
                mul_b = B_WIDTH'(signed'(cfg.gain_i));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        prev_err_next = prev_err_reg;
        filt_next = filt_reg;
        integ_next = integ_reg;
        err_next = err_reg;
        clr_next = clr_reg;
        part_next = part_reg;
        acc_next = acc_reg;
        drive_next = drive_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    err_next = sat_w(SW'(diff_in));
                    clr_next = clear_integrator;
                    op_next = OP_DIFF;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_DIFF:
                        begin
                            part_next = mul_q;
                            op_next = OP_FILT;
                        end
                        OP_FILT:
                        begin
                            filt_next = sat_w(SW'(part_reg) + SW'(mul_q));
                            prev_err_next = err_reg;
                            op_next = OP_INTEG;
                        end
                        OP_INTEG:
                        begin
                            integ_next = sat_w(integ_clamped);
                            op_next = OP_PROP;
                        end
                        OP_PROP:
                        begin
                            acc_next = term(mul_q);
                            op_next = OP_DERIV;
                        end
                        OP_DERIV:
                        begin
                            acc_next = out_sum;
                            op_next = OP_INTGAIN;
                        end
                        OP_INTGAIN:
                        begin
                            if (out_sum > OUT_MAX)
                            begin
                                drive_next = OUT_MAX[IO_WIDTH-1:0];
                            end
                            else if (out_sum < OUT_MIN)
                            begin
                                drive_next = OUT_MIN[IO_WIDTH-1:0];
                            end
                            else
                            begin
                                drive_next = out_sum[IO_WIDTH-1:0];
                            end
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_DIFF;
            prev_err_reg <= '0;
            filt_reg <= '0;
            integ_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            prev_err_reg <= prev_err_next;
            filt_reg <= filt_next;
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        clr_reg <= clr_next;
        part_reg <= part_next;
        acc_reg <= acc_next;
        drive_reg <= drive_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign drive = drive_reg;
    assign mul_start = (state_reg == ST_ISSUE);

endmodule

FILE: src/pid_filtered_derivative_top.sv
// Top level of the filtered-derivative PID channel: configuration registers,
// sequencer core and the shared digit-serial multiplier.
// Depends on pfd_pkg, pfd_in_if, pfd_out_if, pfd_mul and pfd_core.
//
//   channel    direction  contents
//   in_chan    sink       target, measured, clear_integrator
//   out_chan   source     drive
//   cfg_*      write      cfg_write_en, cfg_index, cfg_data
//
// An item runs the six products in turn through the shared multiplier; each product
// passes an issue, a load, one step per 16-bit digit, a rounding and a done step.
// The input is ready only while no item is in work, so a new item is accepted only
// after the previous result is taken; a result holds in its output register until
// taken. Reset clears the filter and integrator state and loads the register defaults.
module pid_filtered_derivative_top #(
    parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [pfd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pfd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    pfd_in_if.sink                                 in_chan,
    pfd_out_if.source                              out_chan
);
    import pfd_pkg::*;

    localparam int AW = DATA_WIDTH + 1;
    localparam int QW = q_width(AW);

    cfg_t                       cfg_reg;
    logic                       mul_start;
    logic signed [AW-1:0]       mul_a;
    logic signed [B_WIDTH-1:0]  mul_b;
    logic                       mul_done;
    logic signed [QW-1:0]       mul_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p <= '0;
            cfg_reg.gain_i <= '0;
            cfg_reg.gain_d <= '0;
            cfg_reg.integral_limit <= LIMIT_RESET;
            cfg_reg.integral_step <= STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_GAIN_P:         cfg_reg.gain_p <= cfg_data;
                REG_GAIN_I:         cfg_reg.gain_i <= cfg_data;
                REG_GAIN_D:         cfg_reg.gain_d <= cfg_data;
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[LIMIT_WIDTH-1:0];
                REG_INTEGRAL_STEP:  cfg_reg.integral_step <= cfg_data[LIMIT_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    pfd_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_chan.valid),
        .in_ready         (in_chan.ready),
        .target           (in_chan.target),
        .measured         (in_chan.measured),
        .clear_integrator (in_chan.clear_integrator),
        .out_valid        (out_chan.valid),
        .out_ready        (out_chan.ready),
        .drive            (out_chan.drive),
        .mul_start        (mul_start),
        .mul_a            (mul_a),
        .mul_b            (mul_b),
        .mul_done         (mul_done),
        .mul_q            (mul_q)
    );

    pfd_mul #(
        .A_WIDTH(AW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .q     (mul_q)
    );

endmodule
